/* design/utf8v_pkg.sv */
package utf8v_pkg;

  localparam int unsigned PosW   = 13;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LimitW = 13;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [AddrW-3:0] REG_COPY_LIMIT = 1'b0;
  localparam logic [LimitW-1:0] COPY_LIMIT_RST = 13'd4095;

  localparam logic [CpW-1:0] CP_MIN_2B    = 21'h00080;
  localparam logic [CpW-1:0] CP_MIN_3B    = 21'h00800;
  localparam logic [CpW-1:0] CP_MIN_4B    = 21'h10000;
  localparam logic [CpW-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO      = 21'h0D800;
  localparam logic [CpW-1:0] SURR_HI      = 21'h0DFFF;

  localparam logic [1:0] MIN_CLASS_2B = 2'd0;
  localparam logic [1:0] MIN_CLASS_3B = 2'd1;
  localparam logic [1:0] MIN_CLASS_4B = 2'd2;

  typedef struct packed {
    logic [1:0]       pending_count;
    logic [CpW-1:0]   codepoint_acc;
    logic [1:0]       min_class;
    logic [PosW-1:0]  byte_position;
    logic             nul_seen;
    logic             error_seen;
    logic             copy_stopped;
    logic [PosW-1:0]  kept_length;
  } dec_state_t;

endpackage

/* design/utf8v_decode.sv */
module utf8v_decode import utf8v_pkg::*; (
  input  dec_state_t        st_i,
  input  logic [7:0]        data_byte_i,
  input  logic [PosW-1:0]   end_pos_i,
  input  logic [LimitW-1:0] copy_limit_i,
  output dec_state_t        st_o
);

  logic [CpW-1:0] acc_next;
  logic [CpW-1:0] cp_min;
  logic           cp_bad;
  logic           fits;

  assign acc_next = {st_i.codepoint_acc[CpW-7:0], data_byte_i[5:0]};
  assign fits     = (end_pos_i <= copy_limit_i);

  always_comb begin
    unique case (st_i.min_class)
      MIN_CLASS_2B: cp_min = CP_MIN_2B;
      MIN_CLASS_3B: cp_min = CP_MIN_3B;
      default:      cp_min = CP_MIN_4B;
    endcase
  end

  assign cp_bad = (acc_next < cp_min) || (acc_next > CP_MAX) ||
                  ((acc_next >= SURR_LO) && (acc_next <= SURR_HI));

  always_comb begin
    st_o = st_i;
    st_o.byte_position = end_pos_i;
    if (!st_i.nul_seen && !st_i.error_seen) begin
      if (st_i.pending_count == 2'd0) begin
        priority if (data_byte_i == 8'h00) begin
          st_o.nul_seen     = 1'b1;
          st_o.copy_stopped = 1'b1;
        end else if (!data_byte_i[7]) begin
          if (!st_i.copy_stopped) begin
            if (fits) st_o.kept_length = end_pos_i;
            else      st_o.copy_stopped = 1'b1;
          end
        end else if (data_byte_i[7:5] == 3'b110) begin
          st_o.pending_count = 2'd1;
          st_o.codepoint_acc = {16'd0, data_byte_i[4:0]};
          st_o.min_class     = MIN_CLASS_2B;
        end else if (data_byte_i[7:4] == 4'b1110) begin
          st_o.pending_count = 2'd2;
          st_o.codepoint_acc = {17'd0, data_byte_i[3:0]};
          st_o.min_class     = MIN_CLASS_3B;
        end else if (data_byte_i[7:3] == 5'b11110) begin
          st_o.pending_count = 2'd3;
          st_o.codepoint_acc = {18'd0, data_byte_i[2:0]};
          st_o.min_class     = MIN_CLASS_4B;
        end else begin
          st_o.error_seen    = 1'b1;
          st_o.copy_stopped  = 1'b1;
          st_o.pending_count = 2'd0;
        end
      end else if (data_byte_i[7:6] != 2'b10) begin
        st_o.error_seen    = 1'b1;
        st_o.copy_stopped  = 1'b1;
        st_o.pending_count = 2'd0;
      end else begin
        st_o.codepoint_acc = acc_next;
        st_o.pending_count = st_i.pending_count - 2'd1;
        if (st_i.pending_count == 2'd1) begin
          if (cp_bad) begin
            st_o.error_seen   = 1'b1;
            st_o.copy_stopped = 1'b1;
          end else if (!st_i.copy_stopped) begin
            if (fits) st_o.kept_length = end_pos_i;
            else      st_o.copy_stopped = 1'b1;
          end
        end
      end
    end
  end

endmodule

/* design/utf8_strict_validate_truncate_core.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o  | data_byte_i[7:0], last_byte_i
// out     | output    | out_valid_o/out_ready_i| text_valid_o, copy_length_o[12:0]
// cfg     | input     | psel/penable/pwrite    | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One byte per cycle unless a last byte stalls; a result loads as its last byte is decoded.
// The byte register feeds the combinational decode into the state and result registers.
// Reset clears decode state, the pipeline valids and sets copy_limit to 4095.
// A held result stalls only a last byte in the byte register; other bytes keep flowing.
module utf8_strict_validate_truncate_core import utf8v_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              text_valid_o,
  output logic [PosW-1:0]   copy_length_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned PosMaxInt = (BUFFER_BYTES < 8191) ? BUFFER_BYTES : 8191;
  localparam logic [PosW-1:0] PosMax = PosW'(PosMaxInt);

  logic [LimitW-1:0] copy_limit_q;
  logic              byte_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  dec_state_t        st_q, st_d;
  logic              out_valid_q;
  logic              text_valid_q;
  logic [PosW-1:0]   copy_length_q;
  logic              out_free;
  logic              proc_fire;
  logic [PosW:0]     pos_inc;
  logic [PosW-1:0]   end_pos;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[AddrW-1:2] == REG_COPY_LIMIT);
  assign prdata = (paddr[AddrW-1:2] == REG_COPY_LIMIT) ?
                  {{(DataW-LimitW){1'b0}}, copy_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_limit_q <= COPY_LIMIT_RST;
    end else if (cfg_wr) begin
      copy_limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc_fire  = byte_valid_q && (!last_q || out_free);
  assign in_ready_o = !byte_valid_q || proc_fire;

  assign pos_inc = {1'b0, st_q.byte_position} + {{PosW{1'b0}}, 1'b1};
  assign end_pos = (pos_inc > {1'b0, PosMax}) ? PosMax : pos_inc[PosW-1:0];

  utf8v_decode u_decode (
    .st_i         (st_q),
    .data_byte_i  (byte_q),
    .end_pos_i    (end_pos),
    .copy_limit_i (copy_limit_q),
    .st_o         (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      byte_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (proc_fire) begin
      st_q <= last_q ? '0 : st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && last_q) begin
      text_valid_q  <= st_d.nul_seen && !st_d.error_seen;
      copy_length_q <= st_d.kept_length;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign text_valid_o  = text_valid_q;
  assign copy_length_o = copy_length_q;

  a_closed_seq_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.nul_seen || st_q.error_seen) |-> (st_q.pending_count == 2'd0))
    else $error("pending continuation after NUL or error");

  a_kept_within_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.kept_length <= st_q.byte_position)
    else $error("kept length beyond byte position");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.byte_position <= PosMax)
    else $error("byte position beyond saturation");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && last_q) |=> (out_valid_q && (st_q == '0)))
    else $error("last item did not load result or clear state");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(proc_fire && last_q))
    else $error("held result overwritten");

endmodule
